### hdl/tdp_pkg.sv
// Types and constants shared by the trapezoidal distance profile block.
// Depends on nothing; every other file but tdp_if imports it.
package tdp_pkg;

	// Divider geometry: the dividend covers v^2 * max_output, the divisor 30 * accel
	localparam int DIVIDEND_W = 48;
	localparam int DIVISOR_W  = 32;
	localparam int DIV_CNT_W  = 6;

	// Field widths
	localparam int DT_W     = 20;
	localparam int POS_W    = 32;
	localparam int VEL_W    = 16;
	localparam int SPEED_W  = 15;
	localparam int ACCEL_W  = 24;
	localparam int OUTPUT_W = 16;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;

	// Step scaler: accel * dt (44 bits) over 2000000 = 2^7 * 15625
	localparam int STEP_NUM_W    = 44;
	localparam int STEP_W        = 24;
	localparam int STEP_T_W      = 30;
	localparam int STEP_RECIP_SH = 44;
	localparam logic [13:0] STEP_ODD   = 14'd15625;
	// ceil(2^44 / 15625), exact for partial dividends below 2^30
	localparam logic [30:0] STEP_RECIP = 31'd1125899907;
	// Stopping distance divisor factor (60 and 2 folded with the Q formats)
	localparam logic [4:0] STOP_DIV = 5'd30;

	// Register reset values
	localparam logic [SPEED_W-1:0]  MAX_SPEED_RST  = 15'd16384;
	localparam logic [ACCEL_W-1:0]  MAX_ACCEL_RST  = 24'd65536;
	localparam logic [OUTPUT_W-1:0] MAX_OUTPUT_RST = 16'd1000;
	localparam logic [DT_W-1:0]     TIMEOUT_RST    = 20'd100000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_SPEED  = 2'd0,
		REG_MAX_ACCEL  = 2'd1,
		REG_MAX_OUTPUT = 2'd2,
		REG_TIMEOUT_US = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRODUCT,
		ST_SCALE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic product;
		logic scale;
		logic div_start;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
	} dp_status_t;

endpackage

### hdl/tdp_if.sv
// Valid/ready channels of the trapezoidal distance profile block: tick words in,
// result words out. Depends on nothing.
interface tdp_tick_if;
	logic               valid;
	logic               ready;
	logic [19:0]        elapsed_us;
	logic signed [31:0] target_distance;
	logic signed [31:0] current_position;
	logic signed [15:0] motor_feedback;

	modport source (
		output valid, elapsed_us, target_distance, current_position, motor_feedback,
		input  ready
	);
	modport sink (
		input  valid, elapsed_us, target_distance, current_position, motor_feedback,
		output ready
	);
endinterface

interface tdp_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] motor_command;
	logic               done_res;
	logic               braking;

	modport source (
		output valid, motor_command, done_res, braking,
		input  ready
	);
	modport sink (
		input  valid, motor_command, done_res, braking,
		output ready
	);
endinterface

### hdl/trapezoidal_distance_profile.sv
// Trapezoidal distance profile: one velocity command word per control tick word.
// Each tick runs from acceptance to a valid result word through the product,
// scale and divider start states, the 48-step bit-serial stopping distance
// divider and one update state. The velocity step is scaled by a reciprocal
// multiply alongside the division. One tick is worked at a time; the next
// tick word is accepted in the cycle after the result is written. The tick
// channel is ready again even if the result word has not been taken; that
// tick then holds its update until the output register is free.
// Configuration writes take effect at once and belong only to idle periods.
// Depends on tdp_pkg, tdp_if, tdp_ctrl, tdp_dp.
module trapezoidal_distance_profile import tdp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	tdp_tick_if.sink             tick,
	tdp_result_if.source         result
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequence the tick through the datapath
	tdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic and state
	tdp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.elapsed_us       (tick.elapsed_us),
		.target_distance  (tick.target_distance),
		.current_position (tick.current_position),
		.motor_feedback   (tick.motor_feedback),
		.cmd              (cmd),
		.status           (status),
		.motor_command    (result.motor_command),
		.done_res         (result.done_res),
		.braking          (result.braking)
	);

endmodule

### hdl/tdp_div.sv
// Restoring unsigned divider, one quotient bit per cycle, and the velocity
// step scaler that divides by a constant. Depends on tdp_pkg for its widths.
module tdp_div import tdp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient
);

	logic                  busy_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    diff;
	logic                  take;

	// Shift in the next dividend bit and try a subtract
	assign rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff   = rem_sh - {1'b0, divisor};
	assign take   = rem_sh >= {1'b0, divisor};

	// Count the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Partial remainder and quotient share one shift register pair
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// Velocity step scaler: drop the factor 2^7 by a shift, then divide by 15625
// with a reciprocal multiply, one 16-bit quotient digit at a time.
module tdp_step_div import tdp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [STEP_NUM_W-1:0] dividend,
	output logic                  busy,
	output logic [STEP_W-1:0]     quotient
);

	logic                busy_q;
	logic [1:0]          phase_q;
	logic [STEP_T_W-1:0] part_q;
	logic [15:0]         low_q;
	logic [15:0]         digit_q;
	logic [7:0]          high_q;
	logic [STEP_W-1:0]   quo_q;
	logic [60:0]         prod;
	logic [STEP_T_W-1:0] back;
	logic [13:0]         rem;

	// Estimate the digit of the partial dividend; remainder from the digit
	assign prod = 61'(part_q) * 61'(STEP_RECIP);
	assign back = STEP_T_W'(digit_q) * STEP_T_W'(STEP_ODD);
	assign rem  = 14'(part_q - back);

	// Walk the four phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= '0;
		end else if (busy_q) begin
			if (phase_q == 2'd3) begin
				busy_q <= 1'b0;
			end
			phase_q <= phase_q + 2'd1;
		end
	end

	// High digit from the top 21 bits, low digit from the remainder and 16 more
	always_ff @(posedge clk) begin
		if (start) begin
			part_q <= STEP_T_W'(dividend[STEP_NUM_W-1:23]);
			low_q  <= dividend[22:7];
		end else if (busy_q) begin
			if (!phase_q[0]) begin
				digit_q <= prod[STEP_RECIP_SH +: 16];
			end else if (!phase_q[1]) begin
				high_q <= digit_q[7:0];
				part_q <= {rem, low_q};
			end else begin
				quo_q <= {high_q, digit_q};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

### hdl/tdp_ctrl.sv
// Sequencer of the trapezoidal distance profile: steps one tick word through
// the datapath and owns the result valid flag. Depends on tdp_pkg.
module tdp_ctrl import tdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        slot_free;

	// The result register can take a word if empty or being drained this cycle
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PRODUCT;
				end
			end
			ST_PRODUCT: begin
				cmd.product = 1'b1;
				state_d     = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_DIV_START;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (!status.div_busy) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the result valid until the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/tdp_dp.sv
// Datapath of the trapezoidal distance profile: configuration registers, move
// state, products, the stopping distance divider, the step scaler and the
// velocity update. Depends on tdp_pkg, tdp_div.
module tdp_dp import tdp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic [DT_W-1:0]          elapsed_us,
	input  logic signed [POS_W-1:0]  target_distance,
	input  logic signed [POS_W-1:0]  current_position,
	input  logic signed [VEL_W-1:0]  motor_feedback,
	input  dp_cmd_t                  cmd,
	output dp_status_t               status,
	output logic signed [VEL_W-1:0]  motor_command,
	output logic                     done_res,
	output logic                     braking
);

	// Configuration
	logic [SPEED_W-1:0]  max_speed_q;
	logic [ACCEL_W-1:0]  max_accel_q;
	logic [OUTPUT_W-1:0] max_output_q;
	logic [DT_W-1:0]     timeout_q;

	// Move state
	logic                    running_q;
	logic                    decel_q;
	logic signed [VEL_W-1:0] velocity_q;
	logic signed [POS_W-1:0] start_pos_q;

	// Per-tick working registers
	logic [DT_W-1:0]          dt_q;
	logic signed [POS_W-1:0]  target_q;
	logic signed [POS_W-1:0]  pos_q;
	logic [31:0]              vv_q;
	logic [STEP_NUM_W-1:0]    accdt_q;
	logic [28:0]              den_q;
	logic signed [34:0]       remain_q;
	logic [46:0]              num_q;
	logic signed [VEL_W-1:0]  cmd_q;
	logic                     done_q;
	logic                     braking_q;

	logic                  timed_out;
	logic [ACCEL_W-1:0]    acc_eff;
	logic [VEL_W-1:0]      vabs;
	logic                  busy_stop;
	logic                  busy_step;
	logic [DIVIDEND_W-1:0] stop_quo;
	logic [STEP_W-1:0]     step_quo;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q  <= MAX_SPEED_RST;
			max_accel_q  <= MAX_ACCEL_RST;
			max_output_q <= MAX_OUTPUT_RST;
			timeout_q    <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAX_SPEED:  max_speed_q  <= cfg_data[SPEED_W-1:0];
				REG_MAX_ACCEL:  max_accel_q  <= cfg_data[ACCEL_W-1:0];
				REG_MAX_OUTPUT: max_output_q <= cfg_data[OUTPUT_W-1:0];
				REG_TIMEOUT_US: timeout_q    <= cfg_data[DT_W-1:0];
				default: ;
			endcase
		end
	end

	assign timed_out = elapsed_us > timeout_q;
	assign acc_eff   = (max_accel_q == '0) ? ACCEL_W'(1) : max_accel_q;
	assign vabs      = velocity_q[VEL_W-1] ? VEL_W'(-velocity_q) : VEL_W'(velocity_q);

	// Velocity update from stopping distance and step
	logic [DIVIDEND_W-1:0] stop_val;
	logic [STEP_W-1:0]  step_val;
	logic signed [25:0] v_ext;
	logic signed [25:0] step_ext;
	logic signed [25:0] vmax_ext;
	logic signed [25:0] v_up;
	logic signed [25:0] v_dn;
	logic signed [25:0] v_new;
	logic [34:0]        rem_mag;
	logic               hit;
	logic               dec_new;
	logic               end_move;
	logic signed [VEL_W-1:0] cmd_new;

	assign stop_val = stop_quo;
	assign step_val = step_quo;
	assign v_ext    = 26'(velocity_q);
	assign step_ext = signed'({2'b00, step_val});
	assign vmax_ext = signed'({11'd0, max_speed_q});
	assign v_up     = v_ext + step_ext;
	assign v_dn     = v_ext - step_ext;
	assign rem_mag  = remain_q[34] ? 35'(-remain_q) : 35'(remain_q);

	always_comb begin
		end_move = 1'b0;
		v_new    = v_ext;
		if (!target_q[POS_W-1]) begin
			// Forward move: brake once the stopping distance covers what is left
			hit     = remain_q[34] || (stop_val >= DIVIDEND_W'(rem_mag));
			dec_new = decel_q || hit;
			if (!dec_new) begin
				v_new = (v_up <= vmax_ext) ? v_up : vmax_ext;
			end else if (v_dn >= 26'sd0) begin
				v_new = v_dn;
			end else begin
				v_new    = '0;
				end_move = 1'b1;
			end
		end else begin
			// Reverse move, mirrored
			hit     = !remain_q[34] || (stop_val >= DIVIDEND_W'(rem_mag));
			dec_new = decel_q || hit;
			if (!dec_new) begin
				v_new = (v_dn >= -vmax_ext) ? v_dn : -vmax_ext;
			end else if (v_up <= 26'sd0) begin
				v_new = v_up;
			end else begin
				v_new    = '0;
				end_move = 1'b1;
			end
		end
		// Negate with saturation of the most negative code
		if (v_new == -26'sd32768) begin
			cmd_new = 16'sh7FFF;
		end else begin
			cmd_new = VEL_W'(-v_new);
		end
	end

	// Move state: seed on capture when not running or timed out, advance on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			decel_q     <= 1'b0;
			velocity_q  <= '0;
			start_pos_q <= '0;
		end else if (cmd.capture) begin
			if (timed_out || !running_q) begin
				running_q   <= 1'b1;
				decel_q     <= 1'b0;
				velocity_q  <= motor_feedback;
				start_pos_q <= current_position;
			end
		end else if (cmd.commit) begin
			running_q  <= !end_move;
			decel_q    <= dec_new;
			velocity_q <= v_new[VEL_W-1:0];
		end
	end

	// Working registers and result word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dt_q     <= timed_out ? '0 : elapsed_us;
			target_q <= target_distance;
			pos_q    <= current_position;
		end
		if (cmd.product) begin
			vv_q     <= vabs * vabs;
			accdt_q  <= acc_eff * dt_q;
			den_q    <= 29'(acc_eff) * 29'(STOP_DIV);
			remain_q <= 35'(target_q) - (35'(pos_q) - 35'(start_pos_q));
		end
		if (cmd.scale) begin
			num_q <= vv_q[30:0] * max_output_q;
		end
		if (cmd.commit) begin
			cmd_q     <= cmd_new;
			done_q    <= end_move;
			braking_q <= dec_new;
		end
	end

	// Stopping distance divider and step scaler run side by side
	tdp_div u_div_stop (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (DIVIDEND_W'(num_q)),
		.divisor  (DIVISOR_W'(den_q)),
		.busy     (busy_stop),
		.quotient (stop_quo)
	);

	tdp_step_div u_div_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (accdt_q),
		.busy     (busy_step),
		.quotient (step_quo)
	);

	assign status.div_busy = busy_stop || busy_step;
	assign motor_command   = cmd_q;
	assign done_res        = done_q;
	assign braking         = braking_q;

endmodule
